FILE: rtl/core/mbfr_pkg.sv
// shared types, constants and helpers for the msb-first bit field reader
// no dependencies; every other file of the block imports this package
package mbfr_pkg;

   localparam int unsigned POS_W        = 24;
   localparam int unsigned VALUE_W      = 32;
   localparam int unsigned FUNC_W       = 3;
   localparam int unsigned BITS_W       = 5;
   localparam int unsigned MULT_W       = 8;
   localparam int unsigned LOAD_ADDR_W  = 12;
   localparam int unsigned BUF_W        = 13;
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned WINDOW_BYTES = 5;
   localparam int unsigned WINDOW_W     = WINDOW_BYTES * BYTE_W;
   // byte index of the window: position over eight plus the window offset
   localparam int unsigned IDX_W        = POS_W - 3 + 1;
   localparam int unsigned CNT_W        = 3;
   localparam int unsigned DIV_CNT_W    = 5;

   localparam logic [POS_W-1:0] POS_MAX = 24'hFFFFFF;

   localparam int unsigned DEF_STORE_BYTES    = 4096;
   localparam int unsigned DEF_MAX_FIELD_BITS = 31;

   typedef enum logic [FUNC_W-1:0] {
      FN_LOAD     = 3'd0,
      FN_PEEK     = 3'd1,
      FN_READ_UNS = 3'd2,
      FN_READ_SGN = 3'd3,
      FN_READ_OFS = 3'd4,
      FN_ALIGN    = 3'd5,
      FN_REWIND   = 3'd6
   } mbfr_func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EXTRACT,
      ST_DIVIDE,
      ST_FINISH
   } mbfr_state_type;

   typedef struct packed {
      logic              done;
      logic [MULT_W-1:0] remainder;
   } mbfr_mod_result_type;

   function automatic logic [BITS_W-1:0] clamp_bits(input logic [BITS_W-1:0] bits,
                                                    input logic [BITS_W-1:0] limit);
      return (bits > limit) ? limit : bits;
   endfunction

endpackage

FILE: rtl/core/mbfr_channels.sv
// valid/ready channel interfaces for the request and response sides
// depends on mbfr_pkg for the field widths
interface mbfr_req_if;
   import mbfr_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [FUNC_W-1:0]      func;
   logic [BITS_W-1:0]      field_bits;
   logic [MULT_W-1:0]      align_multiple;
   logic [LOAD_ADDR_W-1:0] load_address;
   logic [BYTE_W-1:0]      load_byte;

   modport source (output valid, func, field_bits, align_multiple, load_address, load_byte,
                   input ready);
   modport sink   (input valid, func, field_bits, align_multiple, load_address, load_byte,
                   output ready);
endinterface

interface mbfr_rsp_if;
   import mbfr_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] field_value;
   logic [POS_W-1:0]          bit_position;

   modport source (output valid, field_value, bit_position, input ready);
   modport sink   (input valid, field_value, bit_position, output ready);
endinterface

FILE: rtl/core/mbfr_store.sv
// single-port byte store with registered read data
// depends on mbfr_pkg for the byte width
module mbfr_store #(
   parameter int unsigned STORE_BYTES = mbfr_pkg::DEF_STORE_BYTES,
   localparam int unsigned ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
   input  logic                      clock,
   input  logic                      write_enable,
   input  logic [ADDR_W-1:0]         address,
   input  logic [mbfr_pkg::BYTE_W-1:0] write_data,
   output logic [mbfr_pkg::BYTE_W-1:0] read_data
);
   import mbfr_pkg::*;

   logic [BYTE_W-1:0] mem [STORE_BYTES];
   logic [BYTE_W-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[address] <= write_data;
      end
      read_data_ff <= mem[address];
   end

   assign read_data = read_data_ff;

endmodule

FILE: rtl/core/mbfr_mod.sv
// iterative remainder unit: one restoring step per cycle over the position bits
// depends on mbfr_pkg for widths and the result struct
module mbfr_mod (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [mbfr_pkg::POS_W-1:0]      dividend,
   input  logic [mbfr_pkg::MULT_W-1:0]     divisor,
   output mbfr_pkg::mbfr_mod_result_type   result
);
   import mbfr_pkg::*;

   localparam logic [DIV_CNT_W-1:0] STEPS = DIV_CNT_W'(POS_W);

   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic                 done_ff, done_in;
   logic [MULT_W-1:0]    rem_ff, rem_in;
   logic [MULT_W-1:0]    div_ff, div_in;
   logic [POS_W-1:0]     bits_ff, bits_in;
   logic [MULT_W:0]      trial;

   always_comb begin
      trial    = {rem_ff, bits_ff[POS_W-1]};
      count_in = count_ff;
      done_in  = 1'b0;
      rem_in   = rem_ff;
      div_in   = div_ff;
      bits_in  = bits_ff;
      if (start) begin
         count_in = STEPS;
         rem_in   = '0;
         div_in   = divisor;
         bits_in  = dividend;
      end else if (count_ff != '0) begin
         // remainder stays below the divisor, so the trial fits in nine bits
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
         end
         rem_in   = trial[MULT_W-1:0];
         bits_in  = {bits_ff[POS_W-2:0], 1'b0};
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      bits_ff <= bits_in;
   end

   assign result.done      = done_ff;
   assign result.remainder = rem_ff;

endmodule

FILE: rtl/core/msb_first_bit_field_reader.sv
// A request is taken only while the block is idle and returns exactly one response. Load,
// rewind and no-op requests go straight to the finish state; peek and read requests make
// the five byte reads of the single-port store with registered read data, then pass the
// extract and finish states; align with a nonzero multiple first runs the 24 remainder
// steps of the one-bit-per-cycle divider, and with a zero multiple goes straight to finish.
// A finished response sits in an output register and a new request may be taken while it
// waits; the next request's finish state stalls until that response is taken. Store bytes
// at or beyond csr_write_data's buffer size read as zero; bytes never loaded are undefined.
module msb_first_bit_field_reader #(
   parameter int unsigned STORE_BYTES    = mbfr_pkg::DEF_STORE_BYTES,
   parameter int unsigned MAX_FIELD_BITS = mbfr_pkg::DEF_MAX_FIELD_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [mbfr_pkg::BUF_W-1:0] csr_write_data,
   mbfr_req_if.sink                   req_chan,
   mbfr_rsp_if.source                 rsp_chan
);
   import mbfr_pkg::*;

   localparam int unsigned ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam logic [IDX_W-1:0] STORE_LIMIT = IDX_W'(STORE_BYTES);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WINDOW_BYTES);

   mbfr_state_type state_ff, state_in;

   logic [BUF_W-1:0]    buffer_bytes_ff;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [FUNC_W-1:0]   func_ff;
   logic [BITS_W-1:0]   nbits_ff;
   logic [MULT_W-1:0]   mult_ff;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                hit_ff, hit_in;
   logic [WINDOW_W-1:0] window_ff, window_in;
   logic [VALUE_W-1:0]  raw_ff, raw_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [POS_W-1:0]    rsp_pos_ff, rsp_pos_in;

   logic                accept;
   logic                fin_fire;
   logic                mem_we;
   logic                mod_start;
   logic                fetch_step;
   logic [IDX_W-1:0]    fetch_idx;
   logic [IDX_W-1:0]    load_idx;
   logic [IDX_W-1:0]    mem_idx;
   logic [BYTE_W-1:0]   mem_rdata;
   logic [BITS_W-1:0]   req_nbits;
   logic [5:0]          shift_amt;
   logic [WINDOW_W-1:0] shifted;
   logic [VALUE_W-1:0]  field_mask;
   logic [VALUE_W-1:0]  value;
   logic [MULT_W-1:0]   addend;
   logic [POS_W:0]      pos_sum;
   mbfr_mod_result_type mod_result;

   // ---------------- datapath helpers ----------------
   assign req_nbits = clamp_bits(req_chan.field_bits, BITS_W'(MAX_FIELD_BITS));
   assign fetch_idx = IDX_W'(pos_ff[POS_W-1:3]) + IDX_W'(cnt_ff);
   assign load_idx  = IDX_W'(req_chan.load_address);
   assign mem_idx   = (state_ff == ST_IDLE) ? load_idx : fetch_idx;

   mbfr_store #(
      .STORE_BYTES (STORE_BYTES)
   ) u_store (
      .clock        (clock),
      .write_enable (mem_we),
      .address      (mem_idx[ADDR_W-1:0]),
      .write_data   (req_chan.load_byte),
      .read_data    (mem_rdata)
   );

   mbfr_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (pos_ff),
      .divisor  (req_chan.align_multiple),
      .result   (mod_result)
   );

   // ---------------- control outputs ----------------
   always_comb begin
      req_chan.ready = 1'b0;
      fetch_step     = 1'b0;
      fin_fire       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
         end
         ST_FETCH: begin
            fetch_step = 1'b1;
         end
         ST_FINISH: begin
            fin_fire = !rsp_valid_ff || rsp_chan.ready;
         end
         default: begin
         end
      endcase
      accept    = req_chan.valid && req_chan.ready;
      mem_we    = accept && (req_chan.func == FN_LOAD) && (load_idx < STORE_LIMIT);
      mod_start = accept && (req_chan.func == FN_ALIGN) && (req_chan.align_multiple != '0);
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.func inside {FN_PEEK, FN_READ_UNS, FN_READ_SGN, FN_READ_OFS}) begin
                  state_in = ST_FETCH;
               end else if (mod_start) begin
                  state_in = ST_DIVIDE;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FETCH: begin
            if (cnt_ff == LAST_STEP) begin
               state_in = ST_EXTRACT;
            end
         end
         ST_EXTRACT: begin
            state_in = ST_FINISH;
         end
         ST_DIVIDE: begin
            if (mod_result.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (fin_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------- window fetch and field extract ----------------
   always_comb begin
      cnt_in    = accept ? '0 : cnt_ff;
      hit_in    = hit_ff;
      window_in = window_ff;
      if (fetch_step) begin
         cnt_in = cnt_ff + 1'b1;
         // zero fill beyond the buffer size or the store
         hit_in = (fetch_idx < IDX_W'(buffer_bytes_ff)) && (fetch_idx < STORE_LIMIT);
         if (cnt_ff != '0) begin
            window_in = {window_ff[WINDOW_W-BYTE_W-1:0], hit_ff ? mem_rdata : '0};
         end
      end
      field_mask = (VALUE_W'(1) << nbits_ff) - VALUE_W'(1);
      shift_amt  = 6'(WINDOW_W) - 6'(nbits_ff) - 6'(pos_ff[2:0]);
      shifted    = window_ff >> shift_amt;
      raw_in     = (state_ff == ST_EXTRACT) ? (shifted[VALUE_W-1:0] & field_mask) : raw_ff;
   end

   // ---------------- result format and position update ----------------
   always_comb begin
      value  = '0;
      addend = '0;
      case (func_ff)
         FN_PEEK, FN_READ_UNS: begin
            value = raw_ff;
         end
         FN_READ_SGN: begin
            value = raw_ff;
            if (nbits_ff != '0 && raw_ff[nbits_ff - 1'b1]) begin
               value = raw_ff | ~field_mask;
            end
         end
         FN_READ_OFS: begin
            value = raw_ff;
            if (nbits_ff != '0) begin
               value = raw_ff - (VALUE_W'(1) << (nbits_ff - 1'b1));
            end
         end
         default: begin
         end
      endcase
      if (func_ff inside {FN_READ_UNS, FN_READ_SGN, FN_READ_OFS}) begin
         addend = MULT_W'(nbits_ff);
      end else if (func_ff == FN_ALIGN && mult_ff != '0 && mod_result.remainder != '0) begin
         addend = mult_ff - mod_result.remainder;
      end
      pos_sum = {1'b0, pos_ff} + (POS_W+1)'(addend);
      pos_in  = pos_ff;
      if (fin_fire) begin
         if (func_ff == FN_REWIND) begin
            pos_in = '0;
         end else if (pos_sum[POS_W]) begin
            pos_in = POS_MAX;
         end else begin
            pos_in = pos_sum[POS_W-1:0];
         end
      end
      rsp_valid_in = fin_fire || (rsp_valid_ff && !rsp_chan.ready);
      rsp_value_in = fin_fire ? value : rsp_value_ff;
      rsp_pos_in   = fin_fire ? pos_in : rsp_pos_ff;
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         pos_ff          <= '0;
         buffer_bytes_ff <= '0;
         rsp_valid_ff    <= 1'b0;
         cnt_ff          <= '0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         if (csr_write_enable) begin
            buffer_bytes_ff <= csr_write_data;
         end
      end
      if (accept) begin
         func_ff  <= req_chan.func;
         nbits_ff <= req_nbits;
         mult_ff  <= req_chan.align_multiple;
      end
      hit_ff       <= hit_in;
      window_ff    <= window_in;
      raw_ff       <= raw_in;
      rsp_value_ff <= rsp_value_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.field_value  = rsp_value_ff;
   assign rsp_chan.bit_position = rsp_pos_ff;

   // ---------------- assertions ----------------
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted request did not start work");

   a_peek_keeps_pos: assert property (@(posedge clock) disable iff (reset)
      (fin_fire && func_ff == FN_PEEK) |=> $stable(pos_ff))
      else $error("peek moved the position");

   a_rewind_clears: assert property (@(posedge clock) disable iff (reset)
      (fin_fire && func_ff == FN_REWIND) |=> (pos_ff == '0 && rsp_chan.bit_position == '0))
      else $error("rewind did not clear the position");

   a_divide_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      mod_result.done |-> (state_ff == ST_DIVIDE))
      else $error("remainder finished outside an align");

endmodule

FILE: bench/mbfr_result_checker.sv
// response checker for the msb-first bit field reader: watches the request, response and csr
// ports, keeps its own copy of the byte store and read position, and compares every response
// depends on mbfr_pkg and the channel interfaces in mbfr_channels.sv
module mbfr_result_checker
   import mbfr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [BUF_W-1:0] csr_write_data,
   mbfr_req_if              req_mon,
   mbfr_rsp_if              rsp_mon,
   output int unsigned      mismatches,
   output int unsigned      outstanding,
   output int unsigned      results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   position;
   } field_result_type;

   field_result_type   pending_fields [$];
   logic [BYTE_W-1:0]  byte_image [DEF_STORE_BYTES];
   logic [POS_W-1:0]   read_pos;
   logic [BUF_W-1:0]   buffer_size;
   int unsigned        mismatch_count = 0;
   int unsigned        checked_count  = 0;
   int unsigned        pending_count  = 0;

   assign mismatches      = mismatch_count;
   assign outstanding     = pending_count;
   assign results_checked = checked_count;

   task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                  input logic [VALUE_W-1:0] want);
      mismatch_count++;
      $display("mismatch at response %0d: %s got 0x%0h expected 0x%0h",
               checked_count, what, got, want);
   endtask

   // bytes past the buffer size or the store end read as zero
   function automatic logic [BYTE_W-1:0] store_byte(input int unsigned idx);
      if (idx >= buffer_size || idx >= DEF_STORE_BYTES)
         return '0;
      return byte_image[idx];
   endfunction

   function automatic logic [VALUE_W-1:0] window_field(input logic [BITS_W-1:0] n);
      logic [WINDOW_W-1:0] window;
      int unsigned         idx;
      if (n == 0)
         return '0;
      idx    = read_pos >> 3;
      window = '0;
      for (int k = 0; k < WINDOW_BYTES; k++)
         window = {window[WINDOW_W-BYTE_W-1:0], store_byte(idx + k)};
      window = window << read_pos[2:0];
      return VALUE_W'(window >> (WINDOW_W - n));
   endfunction

   function automatic void step_position(input int unsigned amount);
      int unsigned sum;
      sum = read_pos + amount;
      read_pos = (sum > POS_MAX) ? POS_MAX : POS_W'(sum);
   endfunction

   function automatic field_result_type apply_request(input logic [FUNC_W-1:0]      fn,
                                                      input logic [BITS_W-1:0]      bits_in,
                                                      input logic [MULT_W-1:0]      mult,
                                                      input logic [LOAD_ADDR_W-1:0] addr,
                                                      input logic [BYTE_W-1:0]      data);
      field_result_type  r;
      logic [BITS_W-1:0] n;
      logic [MULT_W-1:0] rem;
      n = (bits_in > DEF_MAX_FIELD_BITS) ? BITS_W'(DEF_MAX_FIELD_BITS) : bits_in;
      r.value = '0;
      case (mbfr_func_type'(fn))
         FN_LOAD: begin
            if (addr < DEF_STORE_BYTES)
               byte_image[addr] = data;
         end
         FN_PEEK: r.value = window_field(n);
         FN_READ_UNS: begin
            r.value = window_field(n);
            step_position(n);
         end
         FN_READ_SGN: begin
            r.value = window_field(n);
            if (n != 0 && r.value[n-1])
               r.value |= ~((32'd1 << n) - 32'd1);
            step_position(n);
         end
         FN_READ_OFS: begin
            r.value = window_field(n);
            if (n != 0)
               r.value -= 32'd1 << (n - 1);
            step_position(n);
         end
         FN_ALIGN: begin
            if (mult != 0) begin
               rem = MULT_W'(read_pos % mult);
               if (rem != 0)
                  step_position(mult - rem);
            end
         end
         FN_REWIND: read_pos = '0;
         default: ;
      endcase
      r.position = read_pos;
      return r;
   endfunction

   always @(posedge clock) begin
      field_result_type want;
      if (reset) begin
         read_pos    = '0;
         buffer_size = '0;
         pending_fields.delete();
         pending_count <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_fields.size() == 0) begin
               report_mismatch("response with no request pending", rsp_mon.field_value, '0);
            end else begin
               want = pending_fields.pop_front();
               if (rsp_mon.field_value !== want.value)
                  report_mismatch("field_value", rsp_mon.field_value, want.value);
               if (rsp_mon.bit_position !== want.position)
                  report_mismatch("bit_position", VALUE_W'(rsp_mon.bit_position),
                                  VALUE_W'(want.position));
               checked_count++;
            end
         end
         if (csr_write_enable)
            buffer_size = csr_write_data;
         if (req_mon.valid && req_mon.ready)
            pending_fields.push_back(apply_request(req_mon.func, req_mon.field_bits,
                                                   req_mon.align_multiple, req_mon.load_address,
                                                   req_mon.load_byte));
         pending_count <= pending_fields.size();
      end
   end

endmodule

FILE: bench/tb.sv
// top of the bit field reader bench: clock, reset, request stimulus, response stalls and verdict
// depends on mbfr_pkg, mbfr_channels.sv, the block itself and mbfr_result_checker
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mbfr_pkg::*;

   localparam int unsigned       WATCHDOG_LIMIT   = 5000;
   localparam int unsigned       RANDOM_PER_PHASE = 125;
   localparam int unsigned       FILL_LIMIT       = 256;
   localparam logic [FUNC_W-1:0] FN_UNUSED        = 3'd7;
   localparam logic [BYTE_W-1:0] PATTERN [8] = '{8'hA5, 8'hFF, 8'h00, 8'h80,
                                                 8'h7F, 8'h3C, 8'hC3, 8'h5A};

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_write_enable;
   logic [BUF_W-1:0] csr_write_data;

   mbfr_req_if req_chan ();
   mbfr_rsp_if rsp_chan ();

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned results_checked;
   int unsigned quiet_cycles = 0;
   int unsigned burst_left   = 0;
   int unsigned requests_sent = 0;
   int unsigned phase_count  = 0;
   int unsigned filled_bytes = 0;
   int unsigned buffer_now   = 0;
   int unsigned pos_bound    = 0;
   bit          written [DEF_STORE_BYTES];

   msb_first_bit_field_reader dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

   mbfr_result_checker result_check (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .results_checked  (results_checked)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // response side stalls: the pattern switches between several modes
   initial begin
      int unsigned stall_mode;
      int unsigned mode_left;
      int unsigned tick;
      rsp_chan.ready = 1'b0;
      mode_left = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 4);
            mode_left  = (stall_mode == 4) ? $urandom_range(5, 30) : $urandom_range(20, 200);
         end
         mode_left--;
         tick++;
         case (stall_mode)
            0: rsp_chan.ready <= 1'b1;
            1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            3: rsp_chan.ready <= ((tick % 8) >= 3);
            default: rsp_chan.ready <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // valid stays high across a burst; a gap lowers it only when time passes before the next
   task automatic send_request(input logic [FUNC_W-1:0]      fn,
                               input logic [BITS_W-1:0]      bits,
                               input logic [MULT_W-1:0]      mult,
                               input logic [LOAD_ADDR_W-1:0] addr,
                               input logic [BYTE_W-1:0]      data);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_chan.valid          <= 1'b1;
      req_chan.func           <= fn;
      req_chan.field_bits     <= bits;
      req_chan.align_multiple <= mult;
      req_chan.load_address   <= addr;
      req_chan.load_byte      <= data;
      do @(posedge clock); while (!req_chan.ready);
      burst_left--;
      requests_sent++;
      // track the loaded prefix and an upper bound on the read position
      if (fn == FN_LOAD) begin
         written[addr] = 1'b1;
         while (filled_bytes < DEF_STORE_BYTES && written[filled_bytes])
            filled_bytes++;
      end else if (fn inside {FN_READ_UNS, FN_READ_SGN, FN_READ_OFS}) begin
         pos_bound += bits;
      end else if (fn == FN_ALIGN) begin
         pos_bound += mult;
      end else if (fn == FN_REWIND) begin
         pos_bound = 0;
      end
   endtask

   task automatic command(input logic [FUNC_W-1:0] fn, input logic [BITS_W-1:0] bits,
                          input logic [MULT_W-1:0] mult);
      send_request(fn, bits, mult, LOAD_ADDR_W'($urandom_range(0, DEF_STORE_BYTES - 1)),
                   BYTE_W'($urandom_range(0, 255)));
   endtask

   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // csr writes happen only with every request answered
   task automatic set_buffer_size(input int unsigned size);
      drain_responses();
      csr_write_enable <= 1'b1;
      csr_write_data   <= BUF_W'(size);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      buffer_now = size;
      phase_count++;
   endtask

   task automatic random_request();
      int unsigned       pick;
      logic [BITS_W-1:0] bits;
      logic [MULT_W-1:0] mult;
      logic [FUNC_W-1:0] fn;
      pick = $urandom_range(0, 9);
      bits = (pick == 0) ? 5'd0 : (pick == 1) ? 5'd31 : (pick == 2) ? 5'd1
           : BITS_W'($urandom_range(0, 31));
      pick = $urandom_range(0, 9);
      mult = (pick < 7) ? MULT_W'($urandom_range(1, 32)) : (pick == 7) ? 8'd0
           : MULT_W'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 14)
         fn = FN_LOAD;
      else if (pick < 26)
         fn = FN_PEEK;
      else if (pick < 46)
         fn = FN_READ_UNS;
      else if (pick < 62)
         fn = FN_READ_SGN;
      else if (pick < 76)
         fn = FN_READ_OFS;
      else if (pick < 86)
         fn = FN_ALIGN;
      else if (pick < 92)
         fn = FN_REWIND;
      else if (pick < 94)
         fn = FN_UNUSED;
      else
         fn = FUNC_W'($urandom_range(0, 7));
      // keep the window inside the loaded prefix while the buffer reaches past it
      if ((fn inside {FN_PEEK, FN_READ_UNS, FN_READ_SGN, FN_READ_OFS})
          && buffer_now > filled_bytes && (pos_bound >> 3) + WINDOW_BYTES > filled_bytes)
         fn = FN_REWIND;
      command(fn, bits, mult);
   endtask

   initial begin
      int unsigned sizes [9];
      int unsigned fill_to;
      reset                   = 1'b1;
      csr_write_enable        = 1'b0;
      csr_write_data          = '0;
      req_chan.valid          = 1'b0;
      req_chan.func           = FN_LOAD;
      req_chan.field_bits     = '0;
      req_chan.align_multiple = '0;
      req_chan.load_address   = '0;
      req_chan.load_byte      = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: bytes 6 and 7 sit past the buffer size and must read as zero
      for (int a = 0; a < 8; a++)
         send_request(FN_LOAD, 5'd0, 8'd0, LOAD_ADDR_W'(a), PATTERN[a]);
      send_request(FN_LOAD, 5'd31, 8'd255, 12'hFFF, 8'hFF);
      set_buffer_size(6);
      command(FN_PEEK, 5'd31, 8'd0);
      command(FN_PEEK, 5'd0, 8'd0);
      command(FN_READ_UNS, 5'd0, 8'd0);
      command(FN_READ_SGN, 5'd1, 8'd0);
      command(FN_READ_OFS, 5'd1, 8'd0);
      command(FN_READ_UNS, 5'd31, 8'd0);
      command(FN_ALIGN, 5'd0, 8'd0);
      command(FN_ALIGN, 5'd0, 8'd1);
      command(FN_ALIGN, 5'd0, 8'd255);
      command(FN_UNUSED, 5'd31, 8'd255);
      command(FN_REWIND, 5'd0, 8'd0);
      command(FN_READ_SGN, 5'd31, 8'd0);
      command(FN_READ_OFS, 5'd31, 8'd0);
      command(FN_ALIGN, 5'd0, 8'd8);
      command(FN_PEEK, 5'd31, 8'd0);
      command(FN_REWIND, 5'd0, 8'd0);

      // random phases over a range of buffer sizes, store prefix filled first up to a cap
      sizes = '{0, 1, 3, 64, $urandom_range(5, 200), 4096, 8191, $urandom_range(200, 4096), 4095};
      foreach (sizes[p]) begin
         fill_to = (sizes[p] > FILL_LIMIT) ? FILL_LIMIT : sizes[p];
         for (int a = 0; a < fill_to; a++)
            if (!written[a])
               send_request(FN_LOAD, BITS_W'($urandom_range(0, 31)), MULT_W'($urandom_range(0, 255)),
                            LOAD_ADDR_W'(a), BYTE_W'($urandom_range(0, 255)));
         set_buffer_size(sizes[p]);
         repeat (RANDOM_PER_PHASE) random_request();
      end

      drain_responses();
      repeat (40) @(posedge clock);
      $display("sent %0d requests under %0d buffer sizes", requests_sent, phase_count);
      $display("compared %0d responses, %0d mismatches", results_checked, mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/mbfr_pkg.sv
rtl/core/mbfr_channels.sv
rtl/core/mbfr_store.sv
rtl/core/mbfr_mod.sv
rtl/core/msb_first_bit_field_reader.sv
bench/mbfr_result_checker.sv
bench/tb.sv
